### hw/rtl/cmvdma_pkg.sv
package cmvdma_pkg;

	// payload field widths
	localparam int FUNC_W     = 4;
	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 8;
	localparam int PORT_W     = 3;
	localparam int LINE_W     = 9;
	localparam int KEYS_W     = 10;
	localparam int LATCH_W    = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	// store sizes
	localparam int ROM_DEPTH      = 2048;
	localparam int RAM_DEPTH_DEF  = 512;
	localparam int CART_DEPTH_DEF = 3072;

	// video geometry: four scan lines per frame row, one bit per pixel
	localparam int FIRST_ACTIVE_LINE = 80;
	localparam int ACTIVE_LINES      = 128;
	localparam int SCREEN_WIDTH      = 64;
	localparam int BYTES_PER_LINE    = 8;
	localparam int LINES_PER_ROW     = 4;
	localparam int FRAME_ROWS        = ACTIVE_LINES / LINES_PER_ROW;
	localparam int SCREEN_BYTES      = SCREEN_WIDTH / 8;
	localparam int FRAME_BYTES       = SCREEN_WIDTH * FRAME_ROWS / 8;
	localparam int DMA_WRAP          = SCREEN_WIDTH * ACTIVE_LINES / 8;

	// keys per player
	localparam int KEY_COUNT = 10;

	// memory map boundaries
	localparam logic [ADDR_W-1:0] ADDR_CART_LO = 16'h0400;
	localparam logic [ADDR_W-1:0] ADDR_RAM_LO  = 16'h0800;
	localparam logic [ADDR_W-1:0] ADDR_HIGH_LO = 16'h0C00;
	localparam logic [ADDR_W-1:0] ADDR_HIGH_HI = 16'h1000;

	// i/o ports and fixed bytes
	localparam logic [PORT_W-1:0] IO_PORT_DISPLAY = 3'd1;
	localparam logic [PORT_W-1:0] IO_PORT_KEYS    = 3'd2;
	localparam logic [LATCH_W-1:0] KEY_LATCH_MASK = 4'hF;
	localparam logic [DATA_W-1:0] BYTE_ONES       = 8'hFF;
	localparam logic [DATA_W-1:0] BYTE_ZERO       = 8'h00;

	// action codes
	typedef enum logic [FUNC_W-1:0] {
		FN_MEM_RD    = 4'd0,
		FN_MEM_WR    = 4'd1,
		FN_IO_RD     = 4'd2,
		FN_IO_WR     = 4'd3,
		FN_DMA       = 4'd4,
		FN_SET_KEYS  = 4'd5,
		FN_LOAD_ROM  = 4'd6,
		FN_LOAD_CART = 4'd7,
		FN_FRAME_RD  = 4'd8
	} func_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CART_PRESENT = 1'b0,
		CFG_HIGH_BANK    = 1'b1
	} cfg_index_t;

	// where the result byte comes from
	typedef enum logic [2:0] {
		SRC_ZERO  = 3'd0,
		SRC_ONES  = 3'd1,
		SRC_ROM   = 3'd2,
		SRC_CART  = 3'd3,
		SRC_RAM   = 3'd4,
		SRC_FRAME = 3'd5
	} src_t;

	// address modulo a store depth: the high byte goes through a table of
	// (hi * 256) mod depth, the low byte is added, one subtract corrects
	localparam int MOD_TAB_LEN = 256;
	localparam int MOD_LO_W    = 8;
	typedef logic [11:0] mod_tab_t [MOD_TAB_LEN];

	function automatic mod_tab_t build_mod_tab(input int depth);
		int r;
		mod_tab_t tab;
		r = 0;
		for (int i = 0; i < MOD_TAB_LEN; i++) begin
			tab[i] = 12'(r);
			r = r + MOD_TAB_LEN;
			if (r >= depth) begin
				r = r - depth;
			end
		end
		return tab;
	endfunction

endpackage

### hw/rtl/cmvdma_if.sv
// request channel: one bus action per beat
interface cmvdma_req_if;
	logic                                valid;
	logic                                ready;
	logic [cmvdma_pkg::FUNC_W-1:0]       func;
	logic [cmvdma_pkg::ADDR_W-1:0]       address;
	logic [cmvdma_pkg::DATA_W-1:0]       data;
	logic [cmvdma_pkg::PORT_W-1:0]       port;
	logic [cmvdma_pkg::LINE_W-1:0]       scan_line;
	logic [cmvdma_pkg::KEYS_W-1:0]       keys_player_a;
	logic [cmvdma_pkg::KEYS_W-1:0]       keys_player_b;

	modport source (
		output valid, func, address, data, port, scan_line, keys_player_a, keys_player_b,
		input ready
	);
	modport sink (
		input valid, func, address, data, port, scan_line, keys_player_a, keys_player_b,
		output ready
	);
endinterface

// response channel: one result per beat
interface cmvdma_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cmvdma_pkg::DATA_W-1:0] read_data;
	logic                          key_flag_a_n;
	logic                          key_flag_b_n;
	logic                          display_enable;
	logic                          frame_changed;

	modport source (
		output valid, read_data, key_flag_a_n, key_flag_b_n, display_enable, frame_changed,
		input ready
	);
	modport sink (
		input valid, read_data, key_flag_a_n, key_flag_b_n, display_enable, frame_changed,
		output ready
	);
endinterface

### hw/rtl/console_memory_map_video_dma.sv
// a result is registered in the read stage and then in the output register
// throughput: one action per cycle; each store has one port, used once per action
// stalls on the response side hold the read stage and then the request side
// reset: control state clears at once, then a clearing pass over every store address
// fills rom and cartridge with 0xFF and zeroes ram and frame stores; requests are
// held off until it ends
module console_memory_map_video_dma #(
	parameter int RAM_DEPTH  = cmvdma_pkg::RAM_DEPTH_DEF,
	parameter int CART_DEPTH = cmvdma_pkg::CART_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [cmvdma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cmvdma_pkg::CFG_DATA_W-1:0] cfg_data,
	cmvdma_req_if.sink                        req,
	cmvdma_rsp_if.source                      rsp
);

	localparam int ROM_AW   = $clog2(cmvdma_pkg::ROM_DEPTH);
	localparam int RAM_AW   = $clog2(RAM_DEPTH);
	localparam int CART_AW  = $clog2(CART_DEPTH);
	localparam int FRAME_AW = $clog2(cmvdma_pkg::FRAME_BYTES);
	localparam int DMA_CW   = $clog2(cmvdma_pkg::DMA_WRAP);
	localparam int DW       = cmvdma_pkg::DATA_W;
	localparam int LW       = cmvdma_pkg::LINE_W;
	localparam int AW       = cmvdma_pkg::ADDR_W;
	localparam int LO_W     = cmvdma_pkg::MOD_LO_W;
	localparam int CLR_LEN_A = (cmvdma_pkg::ROM_DEPTH > CART_DEPTH) ?
		cmvdma_pkg::ROM_DEPTH : CART_DEPTH;
	localparam int CLR_LEN  = (CLR_LEN_A > RAM_DEPTH) ? CLR_LEN_A : RAM_DEPTH;
	localparam int CLR_W    = $clog2(CLR_LEN);

	localparam cmvdma_pkg::mod_tab_t RAM_TAB  = cmvdma_pkg::build_mod_tab(RAM_DEPTH);
	localparam cmvdma_pkg::mod_tab_t CART_TAB = cmvdma_pkg::build_mod_tab(CART_DEPTH);

	// stores
	logic [DW-1:0] rom_mem   [cmvdma_pkg::ROM_DEPTH];
	logic [DW-1:0] cart_mem  [CART_DEPTH];
	logic [DW-1:0] ram_mem   [RAM_DEPTH];
	logic [DW-1:0] frame_mem [cmvdma_pkg::FRAME_BYTES];

	// control state
	logic                              clearing_q;
	logic [CLR_W-1:0]                  clr_q;
	logic                              cart_present_q;
	logic                              high_bank_q;
	logic                              display_q;
	logic                              changed_q;
	logic [cmvdma_pkg::LATCH_W-1:0]    latch_q;
	logic [cmvdma_pkg::KEYS_W-1:0]     held_a_q;
	logic [cmvdma_pkg::KEYS_W-1:0]     held_b_q;
	logic [DMA_CW-1:0]                 dma_cnt_q;

	// next state
	logic                              display_d;
	logic                              changed_d;
	logic [cmvdma_pkg::LATCH_W-1:0]    latch_d;
	logic [cmvdma_pkg::KEYS_W-1:0]     held_a_d;
	logic [cmvdma_pkg::KEYS_W-1:0]     held_b_d;
	logic [DMA_CW-1:0]                 dma_cnt_d;
	logic [cmvdma_pkg::KEYS_W-1:0]     sh_a;
	logic [cmvdma_pkg::KEYS_W-1:0]     sh_b;
	logic                              flag_a_n_d;
	logic                              flag_b_n_d;

	// read stage
	logic                              valid_s1;
	cmvdma_pkg::src_t                  src_s1;
	logic                              flag_a_n_s1;
	logic                              flag_b_n_s1;
	logic                              display_s1;
	logic                              changed_s1;
	logic [DW-1:0]                     rom_rdata_s1;
	logic [DW-1:0]                     cart_rdata_s1;
	logic [DW-1:0]                     ram_rdata_s1;
	logic [DW-1:0]                     frame_rdata_s1;

	// output register
	logic                              rsp_valid_q;
	logic [DW-1:0]                     rsp_data_q;
	logic                              rsp_flag_a_n_q;
	logic                              rsp_flag_b_n_q;
	logic                              rsp_display_q;
	logic                              rsp_changed_q;

	// decode
	logic                              accept;
	logic                              out_free;
	logic                              s1_adv;
	cmvdma_pkg::func_t                 fn;
	cmvdma_pkg::src_t                  mem_src;
	cmvdma_pkg::src_t                  src_d;
	logic [AW-1:0]                     a;
	logic [RAM_AW:0]                   ram_sum;
	logic [RAM_AW-1:0]                 ram_idx;
	logic [CART_AW:0]                  cart_sum;
	logic [CART_AW-1:0]                cart_ld_idx;
	logic [CART_AW-1:0]                cart_rd_idx;
	logic [CART_AW-1:0]                cart_idx;
	logic [ROM_AW-1:0]                 rom_idx;
	logic [FRAME_AW-1:0]               frame_rd_idx;
	logic [FRAME_AW-1:0]               dma_idx;
	logic [FRAME_AW-1:0]               frame_idx;
	logic [LW-1:0]                     row;
	logic                              line_active;
	logic                              rom_we;
	logic                              cart_we;
	logic                              ram_we;
	logic                              frame_we;
	logic [DW-1:0]                     rsp_data_d;

	// handshake
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign s1_adv    = valid_s1 && out_free;
	assign req.ready = !clearing_q && (!valid_s1 || out_free);

	assign fn = cmvdma_pkg::func_t'(req.func);
	assign a  = req.address;

	// ram index: address modulo ram depth
	assign ram_sum = (RAM_AW+1)'(RAM_TAB[a[AW-1:LO_W]]) + (RAM_AW+1)'(a[LO_W-1:0]);
	assign ram_idx = (ram_sum >= (RAM_AW+1)'(RAM_DEPTH)) ?
		RAM_AW'(ram_sum - (RAM_AW+1)'(RAM_DEPTH)) : RAM_AW'(ram_sum);

	// cartridge load index: address modulo cartridge depth
	assign cart_sum = (CART_AW+1)'(CART_TAB[a[AW-1:LO_W]]) + (CART_AW+1)'(a[LO_W-1:0]);
	assign cart_ld_idx = (cart_sum >= (CART_AW+1)'(CART_DEPTH)) ?
		CART_AW'(cart_sum - (CART_AW+1)'(CART_DEPTH)) : CART_AW'(cart_sum);

	// cartridge read index: low window or high bank
	assign cart_rd_idx = (a < cmvdma_pkg::ADDR_RAM_LO) ?
		CART_AW'(a - cmvdma_pkg::ADDR_CART_LO) :
		CART_AW'(a - cmvdma_pkg::ADDR_HIGH_LO + cmvdma_pkg::ADDR_RAM_LO);
	assign cart_idx = (fn == cmvdma_pkg::FN_LOAD_CART) ? cart_ld_idx : cart_rd_idx;

	assign rom_idx = ROM_AW'(a);

	// dma target byte: frame row from scan line, column from byte counter
	assign row = req.scan_line - LW'(cmvdma_pkg::FIRST_ACTIVE_LINE);
	assign line_active = (req.scan_line >= LW'(cmvdma_pkg::FIRST_ACTIVE_LINE)) &&
		(row < LW'(cmvdma_pkg::ACTIVE_LINES));
	assign dma_idx = FRAME_AW'(int'(row) / cmvdma_pkg::LINES_PER_ROW * cmvdma_pkg::SCREEN_BYTES
		+ int'(dma_cnt_q) % cmvdma_pkg::BYTES_PER_LINE);
	assign frame_rd_idx = FRAME_AW'(a);
	assign frame_idx = (fn == cmvdma_pkg::FN_DMA) ? dma_idx : frame_rd_idx;

	// write strobes
	assign rom_we   = accept && (fn == cmvdma_pkg::FN_LOAD_ROM);
	assign cart_we  = accept && (fn == cmvdma_pkg::FN_LOAD_CART);
	assign ram_we   = accept && (fn == cmvdma_pkg::FN_MEM_WR) && (a >= cmvdma_pkg::ADDR_RAM_LO);
	assign frame_we = accept && (fn == cmvdma_pkg::FN_DMA) && line_active;

	// memory map decode for cpu reads
	always_comb begin
		priority if (a < cmvdma_pkg::ADDR_CART_LO) begin
			mem_src = cmvdma_pkg::SRC_ROM;
		end else if (a < cmvdma_pkg::ADDR_RAM_LO) begin
			mem_src = cart_present_q ? cmvdma_pkg::SRC_CART : cmvdma_pkg::SRC_ROM;
		end else if ((a >= cmvdma_pkg::ADDR_HIGH_LO) && (a < cmvdma_pkg::ADDR_HIGH_HI) &&
			high_bank_q) begin
			mem_src = cmvdma_pkg::SRC_CART;
		end else begin
			mem_src = cmvdma_pkg::SRC_RAM;
		end
	end

	// next control state and result source
	always_comb begin
		display_d = display_q;
		changed_d = changed_q;
		latch_d   = latch_q;
		held_a_d  = held_a_q;
		held_b_d  = held_b_q;
		dma_cnt_d = dma_cnt_q;
		src_d     = cmvdma_pkg::SRC_ZERO;
		if (accept) begin
			unique case (fn)
				cmvdma_pkg::FN_MEM_RD: begin
					src_d = mem_src;
				end
				cmvdma_pkg::FN_IO_RD: begin
					if (req.port == cmvdma_pkg::IO_PORT_DISPLAY) begin
						display_d = 1'b1;
					end
					src_d = cmvdma_pkg::SRC_ONES;
				end
				cmvdma_pkg::FN_IO_WR: begin
					if (req.port == cmvdma_pkg::IO_PORT_DISPLAY) begin
						display_d = 1'b0;
					end else if (req.port == cmvdma_pkg::IO_PORT_KEYS) begin
						latch_d = req.data[cmvdma_pkg::LATCH_W-1:0] & cmvdma_pkg::KEY_LATCH_MASK;
					end
				end
				cmvdma_pkg::FN_DMA: begin
					if (line_active) begin
						dma_cnt_d = (dma_cnt_q == DMA_CW'(cmvdma_pkg::DMA_WRAP - 1)) ?
							'0 : dma_cnt_q + 1'b1;
						changed_d = 1'b1;
					end
				end
				cmvdma_pkg::FN_SET_KEYS: begin
					held_a_d = req.keys_player_a;
					held_b_d = req.keys_player_b;
				end
				cmvdma_pkg::FN_FRAME_RD: begin
					if (frame_rd_idx == '0) begin
						changed_d = 1'b0;
					end
					src_d = cmvdma_pkg::SRC_FRAME;
				end
				default: begin
				end
			endcase
		end
	end

	// key flags from the latched key number
	assign sh_a = held_a_d >> latch_d;
	assign sh_b = held_b_d >> latch_d;
	assign flag_a_n_d = !((latch_d < cmvdma_pkg::LATCH_W'(cmvdma_pkg::KEY_COUNT)) && sh_a[0]);
	assign flag_b_n_d = !((latch_d < cmvdma_pkg::LATCH_W'(cmvdma_pkg::KEY_COUNT)) && sh_b[0]);

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == CLR_W'(CLR_LEN - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_present_q <= 1'b0;
			high_bank_q    <= 1'b0;
		end else if (cfg_write) begin
			unique case (cmvdma_pkg::cfg_index_t'(cfg_index))
				cmvdma_pkg::CFG_CART_PRESENT: cart_present_q <= cfg_data[0];
				cmvdma_pkg::CFG_HIGH_BANK:    high_bank_q    <= cfg_data[0];
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_q <= 1'b0;
			changed_q <= 1'b0;
			latch_q   <= '0;
			held_a_q  <= '0;
			held_b_q  <= '0;
			dma_cnt_q <= '0;
		end else begin
			display_q <= display_d;
			changed_q <= changed_d;
			latch_q   <= latch_d;
			held_a_q  <= held_a_d;
			held_b_q  <= held_b_d;
			dma_cnt_q <= dma_cnt_d;
		end
	end

	// rom store
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (int'(clr_q) < cmvdma_pkg::ROM_DEPTH) begin
				rom_mem[clr_q[ROM_AW-1:0]] <= cmvdma_pkg::BYTE_ONES;
			end
		end else if (rom_we) begin
			rom_mem[rom_idx] <= req.data;
		end
		if (accept) begin
			rom_rdata_s1 <= rom_mem[rom_idx];
		end
	end

	// cartridge store
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (int'(clr_q) < CART_DEPTH) begin
				cart_mem[clr_q[CART_AW-1:0]] <= cmvdma_pkg::BYTE_ONES;
			end
		end else if (cart_we) begin
			cart_mem[cart_idx] <= req.data;
		end
		if (accept) begin
			cart_rdata_s1 <= cart_mem[cart_idx];
		end
	end

	// ram store, mirrored
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (int'(clr_q) < RAM_DEPTH) begin
				ram_mem[clr_q[RAM_AW-1:0]] <= cmvdma_pkg::BYTE_ZERO;
			end
		end else if (ram_we) begin
			ram_mem[ram_idx] <= req.data;
		end
		if (accept) begin
			ram_rdata_s1 <= ram_mem[ram_idx];
		end
	end

	// frame store, eight pixels per byte, leftmost pixel in the msb
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (int'(clr_q) < cmvdma_pkg::FRAME_BYTES) begin
				frame_mem[clr_q[FRAME_AW-1:0]] <= cmvdma_pkg::BYTE_ZERO;
			end
		end else if (frame_we) begin
			frame_mem[frame_idx] <= req.data;
		end
		if (accept) begin
			frame_rdata_s1 <= frame_mem[frame_idx];
		end
	end

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage payload: status after the action
	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1      <= src_d;
			flag_a_n_s1 <= flag_a_n_d;
			flag_b_n_s1 <= flag_b_n_d;
			display_s1  <= display_d;
			changed_s1  <= changed_d;
		end
	end

	// result byte select
	always_comb begin
		unique case (src_s1)
			cmvdma_pkg::SRC_ONES:  rsp_data_d = cmvdma_pkg::BYTE_ONES;
			cmvdma_pkg::SRC_ROM:   rsp_data_d = rom_rdata_s1;
			cmvdma_pkg::SRC_CART:  rsp_data_d = cart_rdata_s1;
			cmvdma_pkg::SRC_RAM:   rsp_data_d = ram_rdata_s1;
			cmvdma_pkg::SRC_FRAME: rsp_data_d = frame_rdata_s1;
			default:               rsp_data_d = cmvdma_pkg::BYTE_ZERO;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_data_q     <= rsp_data_d;
			rsp_flag_a_n_q <= flag_a_n_s1;
			rsp_flag_b_n_q <= flag_b_n_s1;
			rsp_display_q  <= display_s1;
			rsp_changed_q  <= changed_s1;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_data      = rsp_data_q;
	assign rsp.key_flag_a_n   = rsp_flag_a_n_q;
	assign rsp.key_flag_b_n   = rsp_flag_b_n_q;
	assign rsp.display_enable = rsp_display_q;
	assign rsp.frame_changed  = rsp_changed_q;

	// no request beat is taken during the clearing pass
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req.ready)
		else $error("request accepted during clearing pass");

	// a stalled read stage keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("read stage beat lost under stall");

	// display off after an i/o write to the display port
	a_display_off: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (fn == cmvdma_pkg::FN_IO_WR) && (req.port == cmvdma_pkg::IO_PORT_DISPLAY)
		|=> !display_q)
		else $error("display still on after port write");

	// a stored dma byte marks the frame changed
	a_dma_changed: assert property (@(posedge clk) disable iff (!arst_n)
		frame_we |=> changed_q)
		else $error("changed flag not set by dma byte");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cmvdma_pkg::*;

	localparam int RAM_SIZE     = RAM_DEPTH_DEF;
	localparam int CART_SIZE    = CART_DEPTH_DEF;
	localparam int FRAME_PIXELS = FRAME_BYTES * DATA_W;
	localparam int FUNC_MAX     = (1 << FUNC_W) - 1;
	localparam int ADDR_MAX     = (1 << ADDR_W) - 1;
	localparam int DATA_MAX     = (1 << DATA_W) - 1;
	localparam int PORT_MAX     = (1 << PORT_W) - 1;
	localparam int LINE_MAX     = (1 << LINE_W) - 1;
	localparam int KEYS_MAX     = (1 << KEYS_W) - 1;
	localparam int LAST_ACTIVE  = FIRST_ACTIVE_LINE + ACTIVE_LINES - 1;
	localparam int RANDOM_PER_PHASE = 210;
	localparam int PHASES       = 6;
	localparam int LONG_HOLD    = 300;
	localparam int MAX_REPORTS  = 40;

	// one bus action as offered on the request channel
	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data;
		logic [PORT_W-1:0] port;
		logic [LINE_W-1:0] scan_line;
		logic [KEYS_W-1:0] keys_a;
		logic [KEYS_W-1:0] keys_b;
	} bus_action_t;

	// what the console bus answers for one action
	typedef struct {
		logic [DATA_W-1:0] read_data;
		logic              flag_a_n;
		logic              flag_b_n;
		logic              display;
		logic              changed;
	} bus_reply_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cmvdma_req_if req_ch ();
	cmvdma_rsp_if rsp_ch ();

	console_memory_map_video_dma #(
		.RAM_DEPTH (RAM_SIZE),
		.CART_DEPTH(CART_SIZE)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch.sink),
		.rsp      (rsp_ch.source)
	);

	// console image kept by the bench
	logic [DATA_W-1:0] rom_img [ROM_DEPTH];
	logic [DATA_W-1:0] cart_img [CART_SIZE];
	logic [DATA_W-1:0] ram_img [RAM_SIZE];
	logic              frame_px [FRAME_PIXELS];
	logic [LATCH_W-1:0] key_latch;
	logic [KEYS_W-1:0] held_a;
	logic [KEYS_W-1:0] held_b;
	int unsigned       dma_count;
	logic              display_on;
	logic              frame_dirty;
	logic              cart_in;
	logic              high_bank_on;

	bus_action_t actions_to_send[$];
	bus_reply_t  replies_due[$];
	int          mismatches = 0;

	// idling controls shared with the stimulus
	bit sender_gaps_on   = 1'b1;
	bit receiver_stalls_on = 1'b1;
	int hold_request     = 0;
	int hold_left        = 0;
	int stall_left       = 0;
	int send_gap         = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
		end
	endtask

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 30);
	endfunction

	task automatic clear_console_image();
		foreach (rom_img[i]) rom_img[i] = BYTE_ONES;
		foreach (cart_img[i]) cart_img[i] = BYTE_ONES;
		foreach (ram_img[i]) ram_img[i] = BYTE_ZERO;
		foreach (frame_px[i]) frame_px[i] = 1'b0;
		key_latch    = '0;
		held_a       = '0;
		held_b       = '0;
		dma_count    = 0;
		display_on   = 1'b0;
		frame_dirty  = 1'b0;
		cart_in      = 1'b0;
		high_bank_on = 1'b0;
	endtask

	// carry out one action on the image and give the reply it produces
	function automatic bus_reply_t perform_bus_action(input bus_action_t a);
		bus_reply_t  r;
		int unsigned row;
		int unsigned base;
		int unsigned idx;
		r.read_data = BYTE_ZERO;
		case (a.func)
			FN_MEM_RD: begin
				if (a.address < ADDR_CART_LO) begin
					r.read_data = rom_img[a.address];
				end else if (a.address < ADDR_RAM_LO) begin
					r.read_data = cart_in ? cart_img[(a.address - ADDR_CART_LO) % CART_SIZE]
					                      : rom_img[a.address];
				end else if (a.address >= ADDR_HIGH_LO && a.address < ADDR_HIGH_HI
				             && high_bank_on) begin
					r.read_data = cart_img[(int'(ADDR_RAM_LO) + int'(a.address)
					                        - int'(ADDR_HIGH_LO)) % CART_SIZE];
				end else begin
					r.read_data = ram_img[a.address % RAM_SIZE];
				end
			end
			FN_MEM_WR: begin
				if (a.address >= ADDR_RAM_LO) begin
					ram_img[a.address % RAM_SIZE] = a.data;
				end
			end
			FN_IO_RD: begin
				if (a.port == IO_PORT_DISPLAY) begin
					display_on = 1'b1;
				end
				r.read_data = BYTE_ONES;
			end
			FN_IO_WR: begin
				if (a.port == IO_PORT_DISPLAY) begin
					display_on = 1'b0;
				end else if (a.port == IO_PORT_KEYS) begin
					key_latch = a.data[LATCH_W-1:0] & KEY_LATCH_MASK;
				end
			end
			FN_DMA: begin
				// only active scan lines land in the frame
				if (a.scan_line >= FIRST_ACTIVE_LINE && a.scan_line <= LAST_ACTIVE) begin
					row  = a.scan_line - FIRST_ACTIVE_LINE;
					base = (row / LINES_PER_ROW) * SCREEN_WIDTH
					     + (dma_count % BYTES_PER_LINE) * DATA_W;
					for (int b = 0; b < DATA_W; b++) begin
						frame_px[(base + b) % FRAME_PIXELS] = a.data[DATA_W-1-b];
					end
					dma_count++;
					if (dma_count >= DMA_WRAP) begin
						dma_count = 0;
					end
					frame_dirty = 1'b1;
				end
			end
			FN_SET_KEYS: begin
				held_a = a.keys_a;
				held_b = a.keys_b;
			end
			FN_LOAD_ROM: rom_img[a.address % ROM_DEPTH] = a.data;
			FN_LOAD_CART: cart_img[a.address % CART_SIZE] = a.data;
			FN_FRAME_RD: begin
				idx = a.address % FRAME_BYTES;
				for (int b = 0; b < DATA_W; b++) begin
					r.read_data = {r.read_data[DATA_W-2:0], frame_px[idx * DATA_W + b]};
				end
				if (idx == 0) begin
					frame_dirty = 1'b0;
				end
			end
			default: ;
		endcase
		r.flag_a_n = (key_latch < KEY_COUNT) ? !held_a[key_latch] : 1'b1;
		r.flag_b_n = (key_latch < KEY_COUNT) ? !held_b[key_latch] : 1'b1;
		r.display  = display_on;
		r.changed  = frame_dirty;
		return r;
	endfunction

	function automatic bus_action_t make_action(input int f, input int addr, input int d,
	                                            input int p, input int line,
	                                            input int ka, input int kb);
		bus_action_t a;
		a.func      = FUNC_W'(f);
		a.address   = ADDR_W'(addr);
		a.data      = DATA_W'(d);
		a.port      = PORT_W'(p);
		a.scan_line = LINE_W'(line);
		a.keys_a    = KEYS_W'(ka);
		a.keys_b    = KEYS_W'(kb);
		return a;
	endfunction

	// cpu address with weight on the map boundaries
	function automatic int pick_cpu_address();
		int r;
		int edges [10];
		edges = '{0, ADDR_CART_LO - 1, ADDR_CART_LO, ADDR_RAM_LO - 1, ADDR_RAM_LO,
		          ADDR_HIGH_LO - 1, ADDR_HIGH_LO, ADDR_HIGH_HI - 1, ADDR_HIGH_HI, ADDR_MAX};
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return $urandom_range(0, 2 * ADDR_HIGH_HI - 1);
		end else if (r < 80) begin
			return edges[$urandom_range(0, 9)];
		end
		return $urandom_range(0, ADDR_MAX);
	endfunction

	// one random action with every field random, weighted toward useful content
	function automatic bus_action_t random_action();
		bus_action_t a;
		int r;
		a = make_action(0, $urandom_range(0, ADDR_MAX), $urandom_range(0, DATA_MAX),
		                $urandom_range(0, PORT_MAX), $urandom_range(0, LINE_MAX),
		                $urandom_range(0, KEYS_MAX), $urandom_range(0, KEYS_MAX));
		r = $urandom_range(0, 99);
		if (r < 28) begin
			a.func    = FN_MEM_RD;
			a.address = ADDR_W'(pick_cpu_address());
		end else if (r < 42) begin
			a.func    = FN_MEM_WR;
			a.address = ADDR_W'(pick_cpu_address());
		end else if (r < 48) begin
			a.func = FN_IO_RD;
			if ($urandom_range(0, 1)) a.port = IO_PORT_DISPLAY;
		end else if (r < 56) begin
			a.func = FN_IO_WR;
			case ($urandom_range(0, 2))
				0: a.port = IO_PORT_KEYS;
				1: a.port = IO_PORT_DISPLAY;
				default: ;
			endcase
		end else if (r < 74) begin
			a.func = FN_DMA;
			if ($urandom_range(0, 99) < 85) begin
				a.scan_line = LINE_W'($urandom_range(FIRST_ACTIVE_LINE, LAST_ACTIVE));
			end
		end else if (r < 79) begin
			a.func = FN_SET_KEYS;
		end else if (r < 85) begin
			a.func = FN_LOAD_ROM;
			if ($urandom_range(0, 3) != 0) a.address = ADDR_W'($urandom_range(0, ROM_DEPTH - 1));
		end else if (r < 91) begin
			a.func = FN_LOAD_CART;
			if ($urandom_range(0, 3) != 0) a.address = ADDR_W'($urandom_range(0, CART_SIZE - 1));
		end else if (r < 98) begin
			a.func = FN_FRAME_RD;
			case ($urandom_range(0, 5))
				0: a.address = '0;
				1: ;
				default: a.address = ADDR_W'($urandom_range(0, FRAME_BYTES - 1));
			endcase
		end else begin
			a.func = FUNC_W'($urandom_range(int'(FN_FRAME_RD) + 1, FUNC_MAX));
		end
		return a;
	endfunction

	// a scan line's worth of dma bytes, then a look at the frame
	task automatic queue_video_line();
		int line;
		line = $urandom_range(FIRST_ACTIVE_LINE, LAST_ACTIVE);
		for (int i = 0; i < BYTES_PER_LINE; i++) begin
			actions_to_send.push_back(make_action(FN_DMA, $urandom_range(0, ADDR_MAX),
			                          $urandom_range(0, DATA_MAX), $urandom_range(0, PORT_MAX),
			                          line, $urandom_range(0, KEYS_MAX),
			                          $urandom_range(0, KEYS_MAX)));
		end
		actions_to_send.push_back(make_action(FN_FRAME_RD,
		                          ((line - FIRST_ACTIVE_LINE) / LINES_PER_ROW) * SCREEN_BYTES
		                          + $urandom_range(0, SCREEN_BYTES - 1), 0, 0, 0, 0, 0));
	endtask

	// key mask, latch select, then a read to carry the flags out
	task automatic queue_key_poll();
		actions_to_send.push_back(make_action(FN_SET_KEYS, 0, 0, 0, 0,
		                          $urandom_range(0, KEYS_MAX), $urandom_range(0, KEYS_MAX)));
		actions_to_send.push_back(make_action(FN_IO_WR, 0, $urandom_range(0, DATA_MAX),
		                          IO_PORT_KEYS, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_IO_RD, 0, 0, $urandom_range(0, PORT_MAX),
		                          0, 0, 0));
	endtask

	task automatic write_setting(input cfg_index_t idx, input logic v);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// hold the sender until every reply is back and the pipe is empty
	task automatic wait_idle();
		while (actions_to_send.size() != 0 || req_ch.valid || replies_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		bus_action_t a;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (actions_to_send.size() != 0) begin
				a = actions_to_send.pop_front();
				req_ch.func          <= a.func;
				req_ch.address       <= a.address;
				req_ch.data          <= a.data;
				req_ch.port          <= a.port;
				req_ch.scan_line     <= a.scan_line;
				req_ch.keys_player_a <= a.keys_a;
				req_ch.keys_player_b <= a.keys_b;
				req_ch.valid         <= 1'b1;
				send_gap = sender_gaps_on ? pick_gap() : 0;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response ready: random stalls plus the long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall_left = receiver_stalls_on ? pick_gap() : 0;
			end
		end
	end

	// monitor: settings, accepted requests into the image, replies against it
	always @(posedge clk) begin
		bus_action_t a;
		bus_reply_t  want;
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_CART_PRESENT: cart_in = cfg_data[0];
					CFG_HIGH_BANK: high_bank_on = cfg_data[0];
					default: ;
				endcase
			end
			if (req_ch.valid && req_ch.ready) begin
				a.func      = req_ch.func;
				a.address   = req_ch.address;
				a.data      = req_ch.data;
				a.port      = req_ch.port;
				a.scan_line = req_ch.scan_line;
				a.keys_a    = req_ch.keys_player_a;
				a.keys_b    = req_ch.keys_player_b;
				replies_due.push_back(perform_bus_action(a));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch("reply beat with nothing pending", rsp_ch.read_data, 0);
				end else begin
					want = replies_due.pop_front();
					if (rsp_ch.read_data !== want.read_data)
						report_mismatch("read_data", rsp_ch.read_data, want.read_data);
					if (rsp_ch.key_flag_a_n !== want.flag_a_n)
						report_mismatch("key_flag_a_n", rsp_ch.key_flag_a_n, want.flag_a_n);
					if (rsp_ch.key_flag_b_n !== want.flag_b_n)
						report_mismatch("key_flag_b_n", rsp_ch.key_flag_b_n, want.flag_b_n);
					if (rsp_ch.display_enable !== want.display)
						report_mismatch("display_enable", rsp_ch.display_enable, want.display);
					if (rsp_ch.frame_changed !== want.changed)
						report_mismatch("frame_changed", rsp_ch.frame_changed, want.changed);
				end
			end
		end
	end

	// stimulus
	initial begin
		logic cart_set [PHASES];
		logic bank_set [PHASES];
		int   sent;
		cart_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		bank_set = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

		arst_n               = 1'b0;
		cfg_write            = 1'b0;
		cfg_index            = CFG_CART_PRESENT;
		cfg_data             = '0;
		req_ch.valid         = 1'b0;
		req_ch.func          = FN_MEM_RD;
		req_ch.address       = '0;
		req_ch.data          = '0;
		req_ch.port          = '0;
		req_ch.scan_line     = '0;
		req_ch.keys_player_a = '0;
		req_ch.keys_player_b = '0;
		rsp_ch.ready         = 1'b0;
		clear_console_image();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		write_setting(CFG_CART_PRESENT, 1'b0);
		write_setting(CFG_HIGH_BANK, 1'b0);

		// directed: map edges, every action, the odd corners
		actions_to_send.push_back(make_action(FN_MEM_RD, 0, 0, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_MEM_RD, ADDR_MAX, 0, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_LOAD_ROM, ADDR_MAX, 8'h5A, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_LOAD_CART, ADDR_MAX, 8'hA5, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_LOAD_CART, 0, 8'h3C, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_LOAD_CART, ADDR_RAM_LO, 8'hC3, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_MEM_WR, ADDR_RAM_LO - 1, 8'h77, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_MEM_WR, ADDR_RAM_LO, 8'h12, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_MEM_WR, ADDR_MAX, DATA_MAX, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_MEM_RD, ADDR_RAM_LO + 2 * RAM_SIZE, 0, 0, 0,
		                                      0, 0));
		actions_to_send.push_back(make_action(FN_MEM_RD, ADDR_RAM_LO - 1, 0, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_MEM_RD, ADDR_HIGH_LO, 0, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_IO_RD, 0, 0, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_IO_RD, 0, 0, IO_PORT_DISPLAY, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_IO_WR, 0, DATA_MAX, PORT_MAX, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_IO_WR, 0, 8'hF3, IO_PORT_KEYS, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_SET_KEYS, 0, 0, 0, 0, KEYS_MAX, 10'h008));
		actions_to_send.push_back(make_action(FN_IO_WR, 0, 8'h0A, IO_PORT_KEYS, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_IO_WR, 0, 8'h09, IO_PORT_KEYS, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_IO_WR, 0, 0, IO_PORT_DISPLAY, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_DMA, 0, DATA_MAX, 0, FIRST_ACTIVE_LINE - 1,
		                                      0, 0));
		actions_to_send.push_back(make_action(FN_DMA, 0, 8'h81, 0, FIRST_ACTIVE_LINE, 0, 0));
		actions_to_send.push_back(make_action(FN_DMA, 0, DATA_MAX, 0, LAST_ACTIVE, 0, 0));
		actions_to_send.push_back(make_action(FN_DMA, 0, 8'h55, 0, LAST_ACTIVE + 1, 0, 0));
		actions_to_send.push_back(make_action(FN_DMA, 0, 8'h55, 0, LINE_MAX, 0, 0));
		actions_to_send.push_back(make_action(FN_FRAME_RD, 0, 0, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_FRAME_RD, ADDR_MAX, 0, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FN_MEM_RD, FUNC_MAX, 0, 0, 0, 0, 0));
		actions_to_send.push_back(make_action(FUNC_MAX, ADDR_MAX, DATA_MAX, PORT_MAX, LINE_MAX,
		                                      KEYS_MAX, KEYS_MAX));
		actions_to_send.push_back(make_action(int'(FN_FRAME_RD) + 1, 0, 0, 0, 0, 0, 0));
		wait_idle();

		// random phases, each first writing its cartridge and high-bank setting
		for (int ph = 0; ph < PHASES; ph++) begin
			write_setting(CFG_CART_PRESENT, cart_set[ph]);
			write_setting(CFG_HIGH_BANK, bank_set[ph]);
			sender_gaps_on     = (ph != 3 && ph != 5);
			receiver_stalls_on = (ph != 5);
			if (ph == 3) begin
				hold_request = LONG_HOLD;
			end
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				case ($urandom_range(0, 9))
					0: begin
						queue_video_line();
						sent += BYTES_PER_LINE + 1;
					end
					1: begin
						queue_key_poll();
						sent += 3;
					end
					default: begin
						actions_to_send.push_back(random_action());
						sent++;
					end
				endcase
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
